### design/aeps_pkg.sv
// Package: shared types, constants and status codes for the active/expired scheduler.
package aeps_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int LEVELS_DEF   = 10;
    localparam int MAX_EXEC_DEF = 1023;

    localparam int QW = 10;
    localparam int IDW = 16;
    localparam int TW = 32;
    localparam int LW = 4;

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_FULL     = 3'd1,
        ST_RUN      = 3'd2,
        ST_FINISHED = 3'd3,
        ST_IDLE     = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ISCAN,
        S_IWRITE,
        S_DSCAN,
        S_DSCAN2,
        S_DREAD,
        S_DWAIT,
        S_DEXEC,
        S_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic scan_start;   // clear scan registers, index to 0
        logic scan_step;    // inspect one slot, advance index
        logic scan_inv;     // scan the other set
        logic ins_write;    // write inserted task
        logic ins_full;     // report full
        logic rd;           // read best slot
        logic exec;         // serve the best slot
        logic idle;         // report idle
    } ctrl_t;

    // datapath to controller
    typedef struct packed {
        logic scan_done;
        logic found;
    } stat_t;

endpackage

### design/aeps_ctrl.sv
// Controller state machine of the scheduler.
module aeps_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_fire,
    input  logic              in_mode,
    input  logic              out_busy,
    input  aeps_pkg::stat_t   st,
    output aeps_pkg::ctrl_t   ctl,
    output logic              in_ready,
    output logic              load_out
);

    aeps_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= aeps_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        in_ready   = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            aeps_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_fire)
                begin
                    ctl.scan_start = 1'b1;
                    state_next = in_mode ? aeps_pkg::S_DSCAN : aeps_pkg::S_ISCAN;
                end
            end
            aeps_pkg::S_ISCAN:
            begin
                ctl.scan_step = 1'b1;
                if (st.scan_done)
                    state_next = aeps_pkg::S_IWRITE;
            end
            aeps_pkg::S_IWRITE:
            begin
                if (!out_busy)
                begin
                    if (st.found) ctl.ins_write = 1'b1;
                    else          ctl.ins_full  = 1'b1;
                    load_out   = 1'b1;
                    state_next = aeps_pkg::S_IDLE;
                end
            end
            aeps_pkg::S_DSCAN:
            begin
                ctl.scan_step = 1'b1;
                if (st.scan_done)
                begin
                    if (st.found)
                        state_next = aeps_pkg::S_DREAD;
                    else
                    begin
                        ctl.scan_start = 1'b1;
                        state_next = aeps_pkg::S_DSCAN2;
                    end
                end
            end
            aeps_pkg::S_DSCAN2:
            begin
                ctl.scan_step = 1'b1;
                ctl.scan_inv  = 1'b1;
                if (st.scan_done)
                    state_next = st.found ? aeps_pkg::S_DREAD : aeps_pkg::S_OUT;
            end
            aeps_pkg::S_OUT:
            begin
                if (!out_busy)
                begin
                    ctl.idle   = 1'b1;
                    load_out   = 1'b1;
                    state_next = aeps_pkg::S_IDLE;
                end
            end
            aeps_pkg::S_DREAD:
            begin
                ctl.rd = 1'b1;
                state_next = aeps_pkg::S_DWAIT;
            end
            aeps_pkg::S_DWAIT:
            begin
                state_next = aeps_pkg::S_DEXEC;
            end
            aeps_pkg::S_DEXEC:
            begin
                if (!out_busy)
                begin
                    ctl.exec   = 1'b1;
                    load_out   = 1'b1;
                    state_next = aeps_pkg::S_IDLE;
                end
            end
            default: state_next = aeps_pkg::S_IDLE;
        endcase
    end

endmodule

### design/aeps_dp.sv
// Datapath: slot table, sequential slot scan, service arithmetic and result register.
module aeps_dp #(
    parameter int CAPACITY = aeps_pkg::CAPACITY_DEF,
    parameter int LEVELS   = aeps_pkg::LEVELS_DEF,
    parameter int MAX_EXEC = aeps_pkg::MAX_EXEC_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  aeps_pkg::ctrl_t           ctl,
    input  logic                      in_fire,
    input  logic                      in_mode,
    input  logic [aeps_pkg::IDW-1:0]  in_id,
    input  logic [aeps_pkg::QW-1:0]   in_exec,
    input  logic [aeps_pkg::QW-1:0]   quantum,
    input  logic                      load_out,
    output aeps_pkg::stat_t           st,
    output logic [2:0]                o_status,
    output logic [aeps_pkg::IDW-1:0]  o_id,
    output logic [aeps_pkg::QW-1:0]   o_rem,
    output logic [aeps_pkg::LW-1:0]   o_lvl,
    output logic [aeps_pkg::TW-1:0]   o_resp,
    output logic [aeps_pkg::TW-1:0]   o_turn,
    output logic [aeps_pkg::TW-1:0]   o_time
);

    localparam int AW = $clog2(CAPACITY);
    localparam logic [AW-1:0] LAST = AW'(CAPACITY - 1);
    localparam logic [aeps_pkg::QW-1:0] MAXE =
        (MAX_EXEC > 1023) ? 10'd1023 : aeps_pkg::QW'(MAX_EXEC);
    localparam logic [aeps_pkg::LW-1:0] TOPL = aeps_pkg::LW'(LEVELS - 1);

    // valid, set and started bits stay in flip-flops; keys and payload in memory
    logic [CAPACITY-1:0]      valid_reg;
    logic [CAPACITY-1:0]      tag_reg;
    logic [CAPACITY-1:0]      started_reg;
    logic [aeps_pkg::QW-1:0]  rem_mem   [CAPACITY];
    logic [aeps_pkg::LW-1:0]  lvl_mem   [CAPACITY];
    logic [aeps_pkg::IDW-1:0] id_mem    [CAPACITY];
    logic [aeps_pkg::TW-1:0]  arr_mem   [CAPACITY];
    logic [aeps_pkg::TW-1:0]  first_mem [CAPACITY];

    logic                     atag_reg;
    logic [aeps_pkg::TW-1:0]  clk_cnt_reg;
    logic [AW-1:0]            idx_reg;
    logic                     found_reg;
    logic                     last_reg;
    logic                     ins_mode_reg;
    logic [AW-1:0]            best_reg;
    logic [aeps_pkg::QW-1:0]  best_rem_reg;
    logic [aeps_pkg::LW-1:0]  best_lvl_reg;

    // scan read stage: one slot read per cycle, compared the cycle after
    logic                     cand_vld_reg;
    logic                     cand_reg;
    logic [AW-1:0]            cand_idx_reg;
    logic [aeps_pkg::QW-1:0]  cand_rem_reg;
    logic [aeps_pkg::LW-1:0]  cand_lvl_reg;

    logic [aeps_pkg::IDW-1:0] pid_reg;
    logic [aeps_pkg::QW-1:0]  pexec_reg;
    logic [aeps_pkg::IDW-1:0] rd_id_reg;
    logic [aeps_pkg::TW-1:0]  rd_arr_reg, rd_first_reg;
    logic                     rd_started_reg;

    logic want_tag, better, ins_hit, cmp_hit;

    assign want_tag = atag_reg ^ ctl.scan_inv;
    assign better   = !found_reg ||
                      cand_lvl_reg < best_lvl_reg ||
                      (cand_lvl_reg == best_lvl_reg && cand_rem_reg < best_rem_reg);
    assign ins_hit  = ctl.scan_step && ins_mode_reg && !valid_reg[idx_reg];
    assign cmp_hit  = cand_vld_reg && cand_reg && better;
    assign st.scan_done = ins_mode_reg ? (idx_reg == LAST || !valid_reg[idx_reg]) : last_reg;
    assign st.found     = found_reg || ins_hit || cmp_hit;

    // service arithmetic
    logic [aeps_pkg::QW-1:0]  new_rem;
    logic [aeps_pkg::LW-1:0]  new_lvl;
    logic [aeps_pkg::TW-1:0]  first_t, t_after;
    logic [aeps_pkg::QW-1:0]  ins_rem;
    assign new_rem = (best_rem_reg > quantum) ? best_rem_reg - quantum : '0;
    assign new_lvl = (best_lvl_reg < TOPL) ? best_lvl_reg + aeps_pkg::LW'(1) : best_lvl_reg;
    assign first_t = rd_started_reg ? rd_first_reg : clk_cnt_reg;
    assign t_after = clk_cnt_reg + aeps_pkg::TW'(quantum);
    assign ins_rem = (pexec_reg > MAXE) ? MAXE : pexec_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            atag_reg     <= 1'b0;
            clk_cnt_reg  <= '0;
            idx_reg      <= '0;
            found_reg    <= 1'b0;
            last_reg     <= 1'b0;
            ins_mode_reg <= 1'b0;
            cand_vld_reg <= 1'b0;
        end
        else
        begin
            if (ctl.scan_start)
            begin
                idx_reg   <= '0;
                found_reg <= 1'b0;
                last_reg  <= 1'b0;
            end
            else
            begin
                if (ctl.scan_step && !st.scan_done && idx_reg != LAST)
                    idx_reg <= idx_reg + AW'(1);
                if (ins_hit || cmp_hit)
                    found_reg <= 1'b1;
                // last slot read; its compare lands next cycle
                last_reg <= ctl.scan_step && !ins_mode_reg && idx_reg == LAST && !last_reg;
            end
            cand_vld_reg <= ctl.scan_step && !ins_mode_reg && !last_reg && !ctl.scan_start;
            if (ctl.scan_step && st.scan_done && ctl.scan_inv && st.found)
                atag_reg <= ~atag_reg;
            if (in_fire)
                ins_mode_reg <= !in_mode;
            if (ctl.ins_write)
                valid_reg[best_reg] <= 1'b1;
            else if (ctl.exec && new_rem == '0)
                valid_reg[best_reg] <= 1'b0;
            if (ctl.exec)
                clk_cnt_reg <= t_after;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            pid_reg   <= in_id;
            pexec_reg <= in_exec;
        end
        if (ctl.scan_step && !ins_mode_reg)
        begin
            cand_reg     <= valid_reg[idx_reg] && (tag_reg[idx_reg] == want_tag);
            cand_idx_reg <= idx_reg;
            cand_rem_reg <= rem_mem[idx_reg];
            cand_lvl_reg <= lvl_mem[idx_reg];
        end
        if (ins_hit)
            best_reg <= idx_reg;
        else if (cmp_hit)
        begin
            best_reg     <= cand_idx_reg;
            best_rem_reg <= cand_rem_reg;
            best_lvl_reg <= cand_lvl_reg;
        end
        if (ctl.rd)
        begin
            rd_id_reg      <= id_mem[best_reg];
            rd_arr_reg     <= arr_mem[best_reg];
            rd_first_reg   <= first_mem[best_reg];
            rd_started_reg <= started_reg[best_reg];
        end
        if (ctl.ins_write)
        begin
            id_mem[best_reg]      <= pid_reg;
            arr_mem[best_reg]     <= clk_cnt_reg;
            rem_mem[best_reg]     <= ins_rem;
            lvl_mem[best_reg]     <= '0;
            tag_reg[best_reg]     <= atag_reg;
            started_reg[best_reg] <= 1'b0;
        end
        else if (ctl.exec)
        begin
            started_reg[best_reg] <= 1'b1;
            first_mem[best_reg]   <= first_t;
            rem_mem[best_reg]     <= new_rem;
            if (new_rem != '0)
            begin
                lvl_mem[best_reg] <= new_lvl;
                tag_reg[best_reg] <= ~atag_reg;
            end
        end
        if (load_out)
        begin
            o_resp <= '0;
            o_turn <= '0;
            o_rem  <= '0;
            o_lvl  <= '0;
            o_id   <= '0;
            o_time <= clk_cnt_reg;
            if (ctl.ins_write)
            begin
                o_status <= aeps_pkg::ST_INSERTED;
                o_id     <= pid_reg;
                o_rem    <= ins_rem;
            end
            else if (ctl.ins_full)
            begin
                o_status <= aeps_pkg::ST_FULL;
                o_id     <= pid_reg;
            end
            else if (ctl.idle)
                o_status <= aeps_pkg::ST_IDLE;
            else
            begin
                o_id   <= rd_id_reg;
                o_time <= t_after;
                if (new_rem == '0)
                begin
                    o_status <= aeps_pkg::ST_FINISHED;
                    o_lvl    <= best_lvl_reg;
                    o_resp   <= first_t - rd_arr_reg;
                    o_turn   <= t_after - rd_arr_reg;
                end
                else
                begin
                    o_status <= aeps_pkg::ST_RUN;
                    o_rem    <= new_rem;
                    o_lvl    <= new_lvl;
                end
            end
        end
    end

endmodule

### design/active_expired_priority_scheduler.sv
// Top level of the active/expired priority scheduler.
//
//  channel   | dir | handshake                 | payload
//  s_axis    | in  | s_axis_tvalid/tready      | tuser: mode; tdata: task_id, exec_time (+pad)
//  m_axis    | out | m_axis_tvalid/tready      | tuser: status; tdata: served_id..time_now (+pad)
//  cfg       | in  | cfg_valid/cfg_ready       | cfg_data: quantum
//
// An insert scans slots from 0 up to the lowest free slot, then writes it or reports full.
// A dispatch scans all CAPACITY slots one per cycle plus the last compare
// (twice when the active set is empty), then reads the table (DREAD, DWAIT)
// and serves the best slot (DEXEC).
// The scan unit (one slot per cycle) sets the time each item takes.
// Reset clears valid bits, active tag, time, scan state, quantum (to 1), the state
// machine and the output valid; nothing else.
// The result sits in an output register; a stalled output holds the block
// before its final update, and one item is in flight at a time.
module active_expired_priority_scheduler #(
    parameter int CAPACITY = aeps_pkg::CAPACITY_DEF,
    parameter int LEVELS   = aeps_pkg::LEVELS_DEF,
    parameter int MAX_EXEC = aeps_pkg::MAX_EXEC_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [31:0]   s_axis_tdata,   // [15:0] task_id, [25:16] exec_time
    input  logic          s_axis_tuser,   // [0] mode
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [127:0]  m_axis_tdata,   // [15:0] served_id, [25:16] remaining,
                                          // [29:26] level, [61:30] response_time,
                                          // [93:62] turnaround_time, [125:94] time_now
    output logic [2:0]    m_axis_tuser,   // [2:0] status
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [9:0]    cfg_data
);

    aeps_pkg::ctrl_t ctl;
    aeps_pkg::stat_t st;
    logic            in_fire, load_out, out_busy;
    logic [9:0]      quantum_reg;
    logic            ovalid_reg;

    logic [2:0]  o_status;
    logic [15:0] o_id;
    logic [9:0]  o_rem;
    logic [3:0]  o_lvl;
    logic [31:0] o_resp, o_turn, o_time;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_busy = ovalid_reg && !m_axis_tready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quantum_reg <= 10'd1;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                quantum_reg <= cfg_data;
            if (load_out)
                ovalid_reg <= 1'b1;
            else if (m_axis_tready)
                ovalid_reg <= 1'b0;
        end
    end

    aeps_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .in_mode  (s_axis_tuser),
        .out_busy (out_busy),
        .st       (st),
        .ctl      (ctl),
        .in_ready (s_axis_tready),
        .load_out (load_out)
    );

    aeps_dp #(
        .CAPACITY (CAPACITY),
        .LEVELS   (LEVELS),
        .MAX_EXEC (MAX_EXEC)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .in_fire  (in_fire),
        .in_mode  (s_axis_tuser),
        .in_id    (s_axis_tdata[15:0]),
        .in_exec  (s_axis_tdata[25:16]),
        .quantum  (quantum_reg),
        .load_out (load_out),
        .st       (st),
        .o_status (o_status),
        .o_id     (o_id),
        .o_rem    (o_rem),
        .o_lvl    (o_lvl),
        .o_resp   (o_resp),
        .o_turn   (o_turn),
        .o_time   (o_time)
    );

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {2'd0, o_time, o_turn, o_resp, o_lvl, o_rem, o_id};
    assign m_axis_tuser  = o_status;

endmodule

### design/aeps_checker.sv
// Port-level checker for the scheduler, bound to the top level.
module aeps_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [127:0] m_axis_tdata,
    input logic [2:0]   m_axis_tuser
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tuser <= aeps_pkg::ST_IDLE)
        else $error("bad status");

    a_one: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second item taken while busy");

    a_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == aeps_pkg::ST_IDLE |-> m_axis_tdata[93:0] == '0)
        else $error("idle result carries data");

endmodule

bind active_expired_priority_scheduler aeps_checker u_aeps_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
